### hw/rtl/rbeu_pkg.sv
// Shared types and constants for the register bytecode execute unit.
package rbeu_pkg;

   localparam int NUM_REGS   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int PC_WIDTH   = 16;
   localparam int REG_IDX_W  = 6;
   localparam int RAM_ADDR_W = $clog2(NUM_REGS);
   localparam int DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_EQ     = 4'd4,
      OP_NE     = 4'd5,
      OP_LDI    = 4'd6,
      OP_MOV    = 4'd7,
      OP_JMP    = 4'd8,
      OP_TJMP   = 4'd9,
      OP_REPEAT = 4'd10,
      OP_NOP    = 4'd11,
      OP_EOF    = 4'd12
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_EXEC,
      ST_DIV,
      ST_DIV_WB,
      ST_WR_ITER,
      ST_RESP
   } state_type;

endpackage

### hw/rtl/rbeu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hw/rtl/register_bytecode_execute_unit.sv
// Top level of the register bytecode execute unit: sequencer, register file and divider.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | action, regs, immediate, jump_target
//   rsp     | out       | rsp_valid / rsp_ready  | next_pc, halted, return_value, divide_error
//
// A transaction goes from acceptance to a result in the output register
// through three register file reads on the single read port, an execute
// state and the response load. Repeat adds a state for its second write,
// division adds the iterations of the restoring divider and its write-back.
// Reset is synchronous; it marks every register invalid so that it reads as
// its initial value (register 0 reads 1). EOF does the same.
// A held result stalls only the completion of the next transaction.
module register_bytecode_execute_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [3:0]                           req_action,
   input  logic [rbeu_pkg::REG_IDX_W-1:0]       req_dest_reg,
   input  logic [rbeu_pkg::REG_IDX_W-1:0]       req_src_a_reg,
   input  logic [rbeu_pkg::REG_IDX_W-1:0]       req_src_b_reg,
   input  logic signed [31:0]                   req_immediate,
   input  logic [15:0]                          req_jump_target,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rbeu_pkg::PC_WIDTH-1:0]        rsp_next_pc,
   output logic                                 rsp_halted,
   output logic signed [rbeu_pkg::DATA_WIDTH-1:0] rsp_return_value,
   output logic                                 rsp_divide_error
);

   localparam int DW = rbeu_pkg::DATA_WIDTH;
   localparam int AW = rbeu_pkg::RAM_ADDR_W;
   localparam int IW = rbeu_pkg::REG_IDX_W;
   localparam int PW = rbeu_pkg::PC_WIDTH;
   localparam int CW = rbeu_pkg::DIV_CNT_W;

   rbeu_pkg::state_type state_ff, state_in;

   // Latched transaction fields.
   logic [3:0]    op_ff;
   logic [IW-1:0] d_ff, sa_ff, sb_ff;
   logic [DW-1:0] imm_ff;
   logic [PW-1:0] tgt_ff;

   // Operands and architectural state.
   logic [DW-1:0] a_ff, a_in, b_ff, b_in;
   logic [DW-1:0] reg0_ff, reg0_in;
   logic [PW-1:0] pc_ff, pc_in, next_ff, next_in;
   logic          derr_ff, derr_in;
   logic [rbeu_pkg::NUM_REGS-1:0] valid_ff, valid_in;
   logic [DW-1:0] iter_ff, iter_in;

   // Read tracking for the registered RAM output.
   logic          rv_ff, rin_ff, rzero_ff;
   logic [DW-1:0] rdat;

   // Divider.
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in, dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pc_ff, rsp_pc_in;
   logic          rsp_halt_ff, rsp_halt_in;
   logic [DW-1:0] rsp_ret_ff, rsp_ret_in;
   logic          rsp_derr_ff, rsp_derr_in;

   // RAM port.
   logic          ram_we;
   logic [IW-1:0] ram_waddr_full, ram_raddr_full;
   logic [DW-1:0] ram_wdata;
   logic [DW-1:0] ram_q;

   logic [IW-1:0] rd_idx;
   logic          rd_inrange, wr_inrange;

   rbeu_ram #(.WIDTH(DW), .DEPTH(rbeu_pkg::NUM_REGS)) u_regfile (
      .clock   (clock),
      .wr_en   (ram_we && wr_inrange),
      .wr_addr (ram_waddr_full[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr_full[AW-1:0]),
      .rd_data (ram_q)
   );

   // A register that was never written since reset or EOF reads as its initial value.
   assign rdat = !rin_ff ? '0 : rv_ff ? ram_q : (rzero_ff ? DW'(1) : '0);

   assign ram_raddr_full = rd_idx;
   assign rd_inrange = 32'(rd_idx) < rbeu_pkg::NUM_REGS;
   assign wr_inrange = 32'(ram_waddr_full) < rbeu_pkg::NUM_REGS;

   // Repeat operands as seen after the counter has been decremented.
   logic [DW-1:0] cnt_dec, a_fwd, b_fwd;
   logic          cnt_pos;
   assign cnt_dec = rdat - DW'(1);
   assign cnt_pos = (rdat != '0) && !rdat[DW-1];
   assign a_fwd   = (sa_ff == d_ff) ? cnt_dec : a_ff;
   assign b_fwd   = (sb_ff == d_ff) ? cnt_dec : b_ff;

   logic [DW-1:0] a_mag, b_mag, prod;
   logic [DW:0]   rem_sh;
   logic          resp_free;
   assign a_mag = a_ff[DW-1] ? DW'(-a_ff) : a_ff;
   assign b_mag = b_ff[DW-1] ? DW'(-b_ff) : b_ff;
   assign prod  = DW'(a_ff * b_ff);
   assign rem_sh = {rem_ff[DW-1:0], quo_ff[DW-1]};
   assign resp_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbeu_pkg::ST_IDLE:    if (req_valid) state_in = rbeu_pkg::ST_RD_A;
         rbeu_pkg::ST_RD_A:    state_in = rbeu_pkg::ST_RD_B;
         rbeu_pkg::ST_RD_B:    state_in = rbeu_pkg::ST_RD_C;
         rbeu_pkg::ST_RD_C:    state_in = rbeu_pkg::ST_EXEC;
         rbeu_pkg::ST_EXEC: begin
            if (op_ff == rbeu_pkg::OP_DIV && b_ff != '0) begin
               state_in = rbeu_pkg::ST_DIV;
            end else if (op_ff == rbeu_pkg::OP_REPEAT && cnt_pos) begin
               state_in = rbeu_pkg::ST_WR_ITER;
            end else begin
               state_in = rbeu_pkg::ST_RESP;
            end
         end
         rbeu_pkg::ST_DIV:     if (cnt_ff == CW'(1)) state_in = rbeu_pkg::ST_DIV_WB;
         rbeu_pkg::ST_DIV_WB:  state_in = rbeu_pkg::ST_RESP;
         rbeu_pkg::ST_WR_ITER: state_in = rbeu_pkg::ST_RESP;
         rbeu_pkg::ST_RESP:    if (resp_free) state_in = rbeu_pkg::ST_IDLE;
         default:              state_in = rbeu_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_ready   = (state_ff == rbeu_pkg::ST_IDLE);
      rd_idx      = req_src_a_reg;
      ram_we      = 1'b0;
      ram_waddr_full = d_ff;
      ram_wdata   = '0;
      a_in        = a_ff;
      b_in        = b_ff;
      reg0_in     = reg0_ff;
      pc_in       = pc_ff;
      next_in     = next_ff;
      derr_in     = derr_ff;
      valid_in    = valid_ff;
      iter_in     = iter_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pc_in   = rsp_pc_ff;
      rsp_halt_in = rsp_halt_ff;
      rsp_ret_in  = rsp_ret_ff;
      rsp_derr_in = rsp_derr_ff;

      unique case (state_ff)
         rbeu_pkg::ST_IDLE: begin
            rd_idx  = req_src_a_reg;
            derr_in = 1'b0;
            next_in = pc_ff + PW'(1);
         end
         rbeu_pkg::ST_RD_A: begin
            rd_idx = sb_ff;
            a_in   = rdat;
         end
         rbeu_pkg::ST_RD_B: begin
            rd_idx = d_ff;
            b_in   = rdat;
         end
         rbeu_pkg::ST_RD_C: begin
            rd_idx = d_ff;
         end
         rbeu_pkg::ST_EXEC: begin
            rd_idx = d_ff;
            unique case (op_ff)
               rbeu_pkg::OP_ADD: begin ram_we = 1'b1; ram_wdata = a_ff + b_ff; end
               rbeu_pkg::OP_SUB: begin ram_we = 1'b1; ram_wdata = a_ff - b_ff; end
               rbeu_pkg::OP_MUL: begin ram_we = 1'b1; ram_wdata = prod; end
               rbeu_pkg::OP_EQ:  begin ram_we = 1'b1; ram_wdata = DW'(a_ff == b_ff); end
               rbeu_pkg::OP_NE:  begin ram_we = 1'b1; ram_wdata = DW'(a_ff != b_ff); end
               rbeu_pkg::OP_LDI: begin ram_we = 1'b1; ram_wdata = imm_ff; end
               rbeu_pkg::OP_MOV: begin ram_we = 1'b1; ram_wdata = a_ff; end
               rbeu_pkg::OP_DIV: begin
                  if (b_ff == '0) begin
                     ram_we    = 1'b1;
                     ram_wdata = '0;
                     derr_in   = 1'b1;
                  end
                  rem_in = '0;
                  quo_in = a_mag;
                  dvs_in = b_mag;
                  neg_in = a_ff[DW-1] ^ b_ff[DW-1];
                  cnt_in = CW'(DW);
               end
               rbeu_pkg::OP_JMP:  next_in = tgt_ff;
               rbeu_pkg::OP_TJMP: if (a_ff != '0) next_in = tgt_ff;
               rbeu_pkg::OP_REPEAT: begin
                  if (cnt_pos) begin
                     ram_we    = 1'b1;
                     ram_wdata = cnt_dec;
                     iter_in   = a_fwd + b_fwd;
                  end else begin
                     next_in = tgt_ff;
                  end
               end
               default: ;
            endcase
         end
         rbeu_pkg::ST_DIV: begin
            rd_idx = d_ff;
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
         end
         rbeu_pkg::ST_DIV_WB: begin
            rd_idx    = d_ff;
            ram_we    = 1'b1;
            ram_wdata = neg_ff ? DW'(-quo_ff) : quo_ff;
         end
         rbeu_pkg::ST_WR_ITER: begin
            rd_idx         = d_ff;
            ram_we         = 1'b1;
            ram_waddr_full = sa_ff;
            ram_wdata      = iter_ff;
         end
         rbeu_pkg::ST_RESP: begin
            rd_idx = d_ff;
            if (resp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ret_in   = reg0_ff;
               rsp_derr_in  = derr_ff;
               if (op_ff == rbeu_pkg::OP_EOF) begin
                  rsp_pc_in   = '0;
                  rsp_halt_in = 1'b1;
                  pc_in       = '0;
                  valid_in    = '0;
                  reg0_in     = DW'(1);
               end else begin
                  rsp_pc_in   = next_ff;
                  rsp_halt_in = 1'b0;
                  pc_in       = next_ff;
               end
            end
         end
         default: ;
      endcase

      // Every write marks its entry valid and keeps the copy of register 0 current.
      if (ram_we && wr_inrange) begin
         valid_in[ram_waddr_full[AW-1:0]] = 1'b1;
         if (ram_waddr_full == '0) reg0_in = ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbeu_pkg::ST_IDLE;
         valid_ff     <= '0;
         reg0_ff      <= DW'(1);
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         reg0_ff      <= reg0_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_action;
         d_ff   <= req_dest_reg;
         sa_ff  <= req_src_a_reg;
         sb_ff  <= req_src_b_reg;
         imm_ff <= DW'(req_immediate);
         tgt_ff <= PW'(req_jump_target);
      end
      rv_ff    <= rd_inrange && valid_ff[rd_idx[AW-1:0]];
      rin_ff   <= rd_inrange;
      rzero_ff <= (rd_idx == '0);
      a_ff     <= a_in;
      b_ff     <= b_in;
      next_ff  <= next_in;
      derr_ff  <= derr_in;
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_halt_ff <= rsp_halt_in;
      rsp_ret_ff  <= rsp_ret_in;
      rsp_derr_ff <= rsp_derr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_pc_ff;
   assign rsp_halted       = rsp_halt_ff;
   assign rsp_return_value = rsp_ret_ff;
   assign rsp_divide_error = rsp_derr_ff;

endmodule

### hw/rtl/rbeu_checker.sv
// Port-level checks for the register bytecode execute unit, bound to the top level.
module rbeu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rbeu_pkg::PC_WIDTH-1:0] rsp_next_pc,
   input logic                          rsp_halted
);

   a_halt_pc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> rsp_next_pc == '0)
      else $error("halted transaction reports a nonzero next_pc");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in flight");

   a_rsp_halt_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_halted))
      else $error("stalled response changed its halted flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled response changed");

endmodule

bind register_bytecode_execute_unit rbeu_checker u_rbeu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_next_pc (rsp_next_pc),
   .rsp_halted  (rsp_halted)
);
